// ===== sv/htfa_pkg.sv =====
// Shared types and constants for the hole table fit allocator.
// Depends on nothing; htfa_if, htfa_fit_unit, the top level and the testbench refer to it by scoped names.
package htfa_pkg;

    localparam int SIZE_W   = 17;
    localparam int ADDR_W   = 16;
    localparam int LEN_W    = 17;
    localparam int POLICY_W = 2;

    localparam int MEM_WORDS_DEF = 65536;
    localparam int MAX_HOLES_DEF = 16;

    // Fit policy codes. The unused code behaves as first fit.
    localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
    localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
    localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_SHIFT_RD,
        ST_SHIFT_WR,
        ST_DONE
    } state_t;

    // Verdict of the shared compare unit for one hole.
    typedef struct packed {
        logic take;
        logic fits;
        logic exact;
    } fit_res_t;

endpackage

// ===== sv/htfa_if.sv =====
// Handshake channel interfaces of the hole table fit allocator.
// Depends on htfa_pkg for the field widths.
interface htfa_req_if;
    logic                       valid;
    logic                       ready;
    logic [htfa_pkg::SIZE_W-1:0] request_size;

    modport source (output valid, output request_size, input ready);
    modport sink   (input valid, input request_size, output ready);
endinterface

interface htfa_res_if;
    logic                       valid;
    logic                       ready;
    logic [htfa_pkg::ADDR_W-1:0] granted_address;
    logic                       alloc_failed;

    modport source (output valid, output granted_address, output alloc_failed, input ready);
    modport sink   (input valid, input granted_address, input alloc_failed, output ready);
endinterface

interface htfa_cfg_if;
    logic                         valid;
    logic                         ready;
    logic [htfa_pkg::POLICY_W-1:0] fit_policy;

    modport source (output valid, output fit_policy, input ready);
    modport sink   (input valid, input fit_policy, output ready);
endinterface

// ===== sv/htfa_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Depends on nothing.
module htfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/htfa_fit_unit.sv =====
// Shared compare and subtract unit: judges one hole against the request and the
// best hole so far, and gives the length left over. Depends on htfa_pkg.
module htfa_fit_unit (
    input  logic [htfa_pkg::POLICY_W-1:0] policy,
    input  logic [htfa_pkg::SIZE_W-1:0]   size,
    input  logic [htfa_pkg::LEN_W-1:0]    length,
    input  logic                          best_vld,
    input  logic [htfa_pkg::LEN_W-1:0]    best_len,
    output htfa_pkg::fit_res_t            verdict,
    output logic [htfa_pkg::LEN_W-1:0]    diff
);

    logic fits;
    logic smaller;
    logic larger;

    assign fits    = length >= size;
    assign smaller = length < best_len;
    assign larger  = length > best_len;
    assign diff    = length - size;

    always_comb
    begin
        verdict.fits  = fits;
        verdict.exact = length == size;
        case (policy)
            htfa_pkg::POLICY_BEST:
            begin
                verdict.take = fits && (!best_vld || smaller);
            end
            // Worst fit tracks the largest hole; whether it fits is checked afterward.
            htfa_pkg::POLICY_WORST:
            begin
                verdict.take = !best_vld || larger;
            end
            default:
            begin
                verdict.take = fits && !best_vld;
            end
        endcase
    end

endmodule

// ===== sv/hole_table_fit_allocator.sv =====
// Top level of the hole table fit allocator: sequencer, hole table RAM and shared
// compare unit. Depends on htfa_pkg, htfa_if, htfa_ram and htfa_fit_unit.
//
//  channel | modport | payload                          | transfer when
//  --------+---------+----------------------------------+--------------------------
//  req     | sink    | request_size                     | req.valid && req.ready
//  res     | source  | granted_address, alloc_failed    | res.valid && res.ready
//  cfg     | sink    | fit_policy                       | cfg.valid && cfg.ready
//
// After the request transfer the sequencer makes one RAM read per live hole through the shared
// compare unit, drains the scan, decides and loads the output register. An exact fit also
// shifts down each entry behind the taken hole, with a read and a write state per entry.
// A zero-size request skips the scan and goes straight to loading its result. The request
// side is ready again in the cycle after the result is loaded.
// Reset leaves one hole that spans the whole memory; no clearing pass is needed.
// The result sits in an output register, so a new request can transfer while it waits;
// that request then stalls in its last step until the output register is free.
module hole_table_fit_allocator #(
    parameter int MEM_WORDS = htfa_pkg::MEM_WORDS_DEF,
    parameter int MAX_HOLES = htfa_pkg::MAX_HOLES_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    htfa_req_if.sink   req,
    htfa_res_if.source res,
    htfa_cfg_if.sink   cfg
);

    localparam int IDX_W  = $clog2(MAX_HOLES);
    localparam int CNT_W  = $clog2(MAX_HOLES + 1);
    localparam int ADDR_W = htfa_pkg::ADDR_W;
    localparam int LEN_W  = htfa_pkg::LEN_W;
    localparam int ENT_W  = ADDR_W + LEN_W;

    htfa_pkg::state_t state_reg;
    htfa_pkg::state_t state_next;

    logic [htfa_pkg::POLICY_W-1:0] policy_reg;
    logic [htfa_pkg::SIZE_W-1:0]   size_reg;
    logic [CNT_W-1:0]              count_reg;
    logic [CNT_W-1:0]              scan_idx_reg;
    logic                          data_vld_reg;
    logic [IDX_W-1:0]              rd_idx_reg;
    logic                          e0_wr_reg;
    logic                          chosen_vld_reg;
    logic [IDX_W-1:0]              chosen_idx_reg;
    logic [ADDR_W-1:0]             chosen_start_reg;
    logic [LEN_W-1:0]              chosen_len_reg;
    logic [IDX_W-1:0]              shift_idx_reg;
    logic [ADDR_W-1:0]             res_addr_reg;
    logic                          res_fail_reg;
    logic                          out_valid_reg;
    logic [ADDR_W-1:0]             out_addr_reg;
    logic                          out_fail_reg;

    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [ENT_W-1:0]  ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [ENT_W-1:0]  ram_rdata;

    logic [ADDR_W-1:0] rd_start;
    logic [LEN_W-1:0]  rd_len;
    logic              scan_issue;
    logic [CNT_W-1:0]  shift_nxt;
    logic              shift_more;
    logic              dec_fail;
    logic              out_load;
    logic              accept;

    logic [LEN_W-1:0]   unit_len;
    logic [LEN_W-1:0]   unit_diff;
    htfa_pkg::fit_res_t verdict;

    htfa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_HOLES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Entry 0 holds the whole memory until it is first written.
    always_comb
    begin
        if (rd_idx_reg == '0 && !e0_wr_reg)
        begin
            rd_start = '0;
            rd_len   = LEN_W'(MEM_WORDS);
        end
        else
        begin
            rd_start = ram_rdata[ENT_W-1:LEN_W];
            rd_len   = ram_rdata[LEN_W-1:0];
        end
    end

    assign unit_len = (state_reg == htfa_pkg::ST_DECIDE) ? chosen_len_reg : rd_len;

    htfa_fit_unit u_fit (
        .policy   (policy_reg),
        .size     (size_reg),
        .length   (unit_len),
        .best_vld (chosen_vld_reg),
        .best_len (chosen_len_reg),
        .verdict  (verdict),
        .diff     (unit_diff)
    );

    assign accept     = req.valid && req.ready;
    assign scan_issue = (state_reg == htfa_pkg::ST_SCAN) && (scan_idx_reg < count_reg);
    assign shift_nxt  = CNT_W'(shift_idx_reg) + CNT_W'(1);
    assign shift_more = shift_nxt < count_reg;
    // Outside worst fit the chosen hole is already known to fit.
    assign dec_fail   = !chosen_vld_reg || !verdict.fits;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            htfa_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = (req.request_size == '0) ? htfa_pkg::ST_DONE
                                                          : htfa_pkg::ST_SCAN;
                end
            end
            htfa_pkg::ST_SCAN:
            begin
                if (!scan_issue && !data_vld_reg)
                begin
                    state_next = htfa_pkg::ST_DECIDE;
                end
            end
            htfa_pkg::ST_DECIDE:
            begin
                state_next = (dec_fail || !verdict.exact) ? htfa_pkg::ST_DONE
                                                          : htfa_pkg::ST_SHIFT_RD;
            end
            htfa_pkg::ST_SHIFT_RD:
            begin
                state_next = shift_more ? htfa_pkg::ST_SHIFT_WR : htfa_pkg::ST_DONE;
            end
            htfa_pkg::ST_SHIFT_WR:
            begin
                state_next = htfa_pkg::ST_SHIFT_RD;
            end
            htfa_pkg::ST_DONE:
            begin
                if (!out_valid_reg || res.ready)
                begin
                    state_next = htfa_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = htfa_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req.ready = 1'b0;
        ram_re    = 1'b0;
        ram_raddr = scan_idx_reg[IDX_W-1:0];
        ram_we    = 1'b0;
        ram_waddr = chosen_idx_reg;
        ram_wdata = {ADDR_W'(chosen_start_reg + size_reg[ADDR_W-1:0]), unit_diff};
        out_load  = 1'b0;
        case (state_reg)
            htfa_pkg::ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            htfa_pkg::ST_SCAN:
            begin
                ram_re = scan_issue;
            end
            htfa_pkg::ST_DECIDE:
            begin
                ram_we = !dec_fail && !verdict.exact;
            end
            htfa_pkg::ST_SHIFT_RD:
            begin
                ram_re    = shift_more;
                ram_raddr = shift_nxt[IDX_W-1:0];
            end
            htfa_pkg::ST_SHIFT_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = shift_idx_reg;
                ram_wdata = {rd_start, rd_len};
            end
            htfa_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || res.ready;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= htfa_pkg::ST_IDLE;
            policy_reg     <= htfa_pkg::POLICY_FIRST;
            count_reg      <= CNT_W'(1);
            scan_idx_reg   <= '0;
            data_vld_reg   <= 1'b0;
            e0_wr_reg      <= 1'b0;
            chosen_vld_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg.valid && cfg.ready)
            begin
                policy_reg <= cfg.fit_policy;
            end
            if (accept)
            begin
                scan_idx_reg   <= '0;
                chosen_vld_reg <= 1'b0;
                data_vld_reg   <= 1'b0;
            end
            else if (state_reg == htfa_pkg::ST_SCAN)
            begin
                data_vld_reg <= scan_issue;
                if (scan_issue)
                begin
                    scan_idx_reg <= scan_idx_reg + CNT_W'(1);
                end
                if (data_vld_reg && verdict.take)
                begin
                    chosen_vld_reg <= 1'b1;
                end
            end
            if (ram_we && ram_waddr == '0)
            begin
                e0_wr_reg <= 1'b1;
            end
            if (state_reg == htfa_pkg::ST_SHIFT_RD && !shift_more)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            size_reg     <= req.request_size;
            res_addr_reg <= '0;
            res_fail_reg <= 1'b1;
        end
        if (ram_re)
        begin
            rd_idx_reg <= ram_raddr;
        end
        if (state_reg == htfa_pkg::ST_SCAN && data_vld_reg && verdict.take)
        begin
            chosen_idx_reg   <= rd_idx_reg;
            chosen_start_reg <= rd_start;
            chosen_len_reg   <= rd_len;
        end
        if (state_reg == htfa_pkg::ST_DECIDE)
        begin
            res_addr_reg  <= dec_fail ? '0 : chosen_start_reg;
            res_fail_reg  <= dec_fail;
            shift_idx_reg <= chosen_idx_reg;
        end
        if (state_reg == htfa_pkg::ST_SHIFT_WR)
        begin
            shift_idx_reg <= shift_nxt[IDX_W-1:0];
        end
        if (out_load)
        begin
            out_addr_reg <= res_addr_reg;
            out_fail_reg <= res_fail_reg;
        end
    end

    assign cfg.ready           = 1'b1;
    assign res.valid           = out_valid_reg;
    assign res.granted_address = out_addr_reg;
    assign res.alloc_failed    = out_fail_reg;

`ifndef SYNTHESIS
    // Without freeing, the table can only lose holes.
    a_count_never_grows: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= $past(count_reg))
        else $error("hole count increased");

    a_count_drops_after_shift: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != $past(count_reg) |-> $past(state_reg) == htfa_pkg::ST_SHIFT_RD)
        else $error("hole count changed outside the shift sequence");

    a_write_inside_table: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> CNT_W'(ram_waddr) < count_reg)
        else $error("table write beyond the live holes");

    a_busy_after_transfer: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg != htfa_pkg::ST_IDLE && !req.ready)
        else $error("request side ready right after a transfer");
`endif

endmodule

// ===== verif/testbench.sv =====
// Testbench for the hole table fit allocator: policy writes and size requests go in,
// every grant is checked against a private copy of the hole table kept here.
// Depends on htfa_pkg, the channel interfaces in htfa_if and the top level of the block.

class grant_tracker;
    typedef struct packed {
        logic [htfa_pkg::ADDR_W-1:0] addr;
        logic                        failed;
    } grant_t;

    logic [htfa_pkg::ADDR_W-1:0]   hole_base [htfa_pkg::MAX_HOLES_DEF];
    logic [htfa_pkg::LEN_W-1:0]    hole_words [htfa_pkg::MAX_HOLES_DEF];
    int unsigned                   live_holes;
    logic [htfa_pkg::POLICY_W-1:0] policy;
    grant_t                        due_grants [$];
    int                            mismatches;

    function new();
        foreach (hole_base[i])
        begin
            hole_base[i]  = '0;
            hole_words[i] = '0;
        end
        hole_words[0] = htfa_pkg::MEM_WORDS_DEF[htfa_pkg::LEN_W-1:0];
        live_holes    = 1;
        policy        = htfa_pkg::POLICY_FIRST;
        mismatches    = 0;
    endfunction

    function void set_policy(input logic [htfa_pkg::POLICY_W-1:0] p);
        policy = p;
    endfunction

    function int pending();
        return due_grants.size();
    endfunction

    function logic [htfa_pkg::LEN_W-1:0] largest_hole();
        logic [htfa_pkg::LEN_W-1:0] most;
        most = '0;
        for (int i = 0; i < live_holes; i++)
        begin
            if (hole_words[i] > most)
                most = hole_words[i];
        end
        return most;
    endfunction

    // Index of the hole the current policy takes, or -1 when none will do.
    function int find_hole(input logic [htfa_pkg::SIZE_W-1:0] size);
        int chosen;
        int n;
        chosen = -1;
        n = (live_holes > htfa_pkg::MAX_HOLES_DEF) ? htfa_pkg::MAX_HOLES_DEF : live_holes;
        if (policy == htfa_pkg::POLICY_WORST)
        begin
            for (int i = 0; i < n; i++)
            begin
                if (chosen < 0 || hole_words[i] > hole_words[chosen])
                    chosen = i;
            end
            // Worst fit looks only at the largest hole.
            if (chosen >= 0 && hole_words[chosen] < size)
                chosen = -1;
        end
        else if (policy == htfa_pkg::POLICY_BEST)
        begin
            for (int i = 0; i < n; i++)
            begin
                if (hole_words[i] >= size &&
                    (chosen < 0 || hole_words[i] < hole_words[chosen]))
                    chosen = i;
            end
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                if (chosen < 0 && hole_words[i] >= size)
                    chosen = i;
            end
        end
        return chosen;
    endfunction

    function void note_request(input logic [htfa_pkg::SIZE_W-1:0] size);
        grant_t g;
        int     k;
        int     n;
        g.addr   = '0;
        g.failed = 1'b1;
        k = (size == 0) ? -1 : find_hole(size);
        if (k >= 0)
        begin
            g.addr   = hole_base[k];
            g.failed = 1'b0;
            if (hole_words[k] == size)
            begin
                n = (live_holes > htfa_pkg::MAX_HOLES_DEF) ? htfa_pkg::MAX_HOLES_DEF
                                                           : live_holes;
                for (int j = k; j + 1 < n; j++)
                begin
                    hole_base[j]  = hole_base[j + 1];
                    hole_words[j] = hole_words[j + 1];
                end
                hole_base[n - 1]  = '0;
                hole_words[n - 1] = '0;
                live_holes        = n - 1;
            end
            else
            begin
                hole_base[k]  = hole_base[k] + size[htfa_pkg::ADDR_W-1:0];
                hole_words[k] = hole_words[k] - size;
            end
        end
        due_grants.push_back(g);
    endfunction

    task report(input string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    task check_grant(input logic [htfa_pkg::ADDR_W-1:0] addr, input logic failed);
        grant_t want;
        if (due_grants.size() == 0)
        begin
            report($sformatf("result with nothing outstanding: address %0d failed %0b",
                             addr, failed));
            return;
        end
        want = due_grants.pop_front();
        if (addr !== want.addr)
            report($sformatf("granted_address %0d, predicted %0d", addr, want.addr));
        if (failed !== want.failed)
            report($sformatf("alloc_failed %0b, predicted %0b", failed, want.failed));
    endtask

    task close_out();
        if (due_grants.size() != 0)
            report($sformatf("%0d results never arrived", due_grants.size()));
    endtask
endclass

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REQ_W = htfa_pkg::SIZE_W;
    localparam logic [htfa_pkg::POLICY_W-1:0] POLICY_SPARE = 2'd3;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int SETTLE_CYCLES    = 64;
    localparam int RANDOM_PER_PHASE = 105;
    localparam int LONG_HOLD        = 400;

    logic        clk;
    logic        rst_n;
    int unsigned cycles = 0;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_cycles;

    grant_tracker book = new();

    htfa_req_if req_ch();
    htfa_res_if res_ch();
    htfa_cfg_if cfg_ch();

    hole_table_fit_allocator dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .res   (res_ch),
        .cfg   (cfg_ch)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[hole_table_fit_allocator] ERROR");
            $finish;
        end
    end

    // Result side: check each transfer, then decide ready for the next edge.
    initial
    begin
        res_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_ch.valid && res_ch.ready)
                book.check_grant(res_ch.granted_address, res_ch.alloc_failed);
            if (hold_cycles > 0)
            begin
                hold_cycles = hold_cycles - 1;
                res_ch.ready <= 1'b0;
            end
            else
                res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_request(input logic [REQ_W-1:0] size);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.request_size <= size;
        do
            @(posedge clk);
        while (!req_ch.ready);
        book.note_request(size);
    endtask

    task automatic drain_results();
        req_ch.valid <= 1'b0;
        while (book.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_policy(input logic [htfa_pkg::POLICY_W-1:0] p);
        cfg_ch.valid      <= 1'b1;
        cfg_ch.fit_policy <= p;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        book.set_policy(p);
        cfg_ch.valid <= 1'b0;
    endtask

    // Mostly small sizes so the memory lasts; near the end, sizes aimed at the
    // largest hole, to use it up exactly or to miss it by one word.
    function automatic logic [REQ_W-1:0] pick_size(input bit closing);
        logic [htfa_pkg::LEN_W-1:0] most;
        int unsigned                roll;
        most = book.largest_hole();
        roll = $urandom_range(99);
        if (closing && most != 0 && roll < 20)
            return most;
        if (closing && roll < 30)
            return most + 1'b1;
        if (roll < 4)
            return REQ_W'($urandom_range(0, 131071));
        if (roll < 14)
            return REQ_W'($urandom_range(1, 512));
        return REQ_W'($urandom_range(1, 32));
    endfunction

    task automatic run_phase(input logic [htfa_pkg::POLICY_W-1:0] p, input int s_pct,
                             input int r_pct, input int hold, input bit closing);
        drain_results();
        write_policy(p);
        send_idle_pct  = s_pct;
        recv_stall_pct = r_pct;
        hold_cycles    = hold;
        for (int i = 0; i < RANDOM_PER_PHASE; i++)
            send_request(pick_size(closing));
    endtask

    initial
    begin
        logic [htfa_pkg::LEN_W-1:0] left;
        rst_n               <= 1'b0;
        req_ch.valid        <= 1'b0;
        req_ch.request_size <= '0;
        cfg_ch.valid        <= 1'b0;
        cfg_ch.fit_policy   <= '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_cycles    = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_policy(htfa_pkg::POLICY_FIRST);
        send_request(0);
        send_request(131071);
        send_request(65537);
        send_request(1);
        send_request(2);
        send_request(65536);
        send_request(REQ_W'(book.largest_hole()) + 1'b1);
        send_request(100);
        send_request(1023);

        // The first random phase opens with a long receiver hold-off so the block backs up.
        run_phase(htfa_pkg::POLICY_BEST,  0,  0,  LONG_HOLD, 1'b0);
        run_phase(htfa_pkg::POLICY_WORST, 52, 0,  0,         1'b0);
        run_phase(POLICY_SPARE,           0,  52, 0,         1'b0);
        run_phase(htfa_pkg::POLICY_FIRST, 13, 13, 0,         1'b0);
        run_phase(htfa_pkg::POLICY_WORST, 13, 13, 0,         1'b1);

        // Use up the largest hole that is left, then ask for one word, zero words and the largest size.
        left = book.largest_hole();
        if (left != 0)
            send_request(left);
        send_request(1);
        send_request(0);
        send_request(131071);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        book.close_out();
        if (book.mismatches == 0)
            $display("[hole_table_fit_allocator] OK");
        else
            $display("[hole_table_fit_allocator] ERROR");
        $finish;
    end
endmodule

// ===== hole_table_fit_allocator.f =====
sv/htfa_pkg.sv
sv/htfa_if.sv
sv/htfa_ram.sv
sv/htfa_fit_unit.sv
sv/hole_table_fit_allocator.sv
verif/testbench.sv
